// ----- rtl/core/gsfbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsfbf_pkg
// Shared widths and constants for the shortest-first budget fill core.
// ----------------------------------------------------------------------------
package gsfbf_pkg;

   localparam int FIELD_W           = 6;     // minutes / seconds fields
   localparam int DUR_W             = 12;    // duration in seconds
   localparam int QUOT_W            = 7;     // 4095 / 60 = 68 needs 7 bits
   localparam int SECS_PER_MIN      = 60;
   // floor(d / 60) estimate: (d * 1092) >> 16 is exact or one low for d < 4096
   localparam int RECIP_60          = 1092;
   localparam int RECIP_W           = 11;
   localparam int RECIP_SHIFT       = 16;
   localparam int PROD_W            = DUR_W + RECIP_W;
   localparam int MAX_ITEMS_DEFAULT = 32;

   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [DUR_W-1:0]   dur_type;

endpackage : gsfbf_pkg
`default_nettype wire

// ----- rtl/core/gsfbf_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsfbf_req_if
// Valid/ready channel carrying one duration (minutes, seconds, end of set).
// ----------------------------------------------------------------------------
interface gsfbf_req_if
   import gsfbf_pkg::*;
   ;
   logic      valid;
   logic      ready;
   field_type minutes;
   field_type seconds;
   logic      last_item;

   modport source (output valid, output minutes, output seconds, output last_item,
                   input ready);
   modport sink   (input valid, input minutes, input seconds, input last_item,
                   output ready);
endinterface : gsfbf_req_if
`default_nettype wire

// ----- rtl/core/gsfbf_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsfbf_rsp_if
// Valid/ready channel carrying one selected duration and its flags.
// ----------------------------------------------------------------------------
interface gsfbf_rsp_if
   import gsfbf_pkg::*;
   ;
   logic      valid;
   logic      ready;
   field_type out_minutes;
   field_type out_seconds;
   logic      is_valid;
   logic      last_result;

   modport source (output valid, output out_minutes, output out_seconds,
                   output is_valid, output last_result, input ready);
   modport sink   (input valid, input out_minutes, input out_seconds,
                   input is_valid, input last_result, output ready);
endinterface : gsfbf_rsp_if
`default_nettype wire

// ----- rtl/core/greedy_shortest_first_budget_fill_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_shortest_first_budget_fill_core
// Collects durations into a sorted store, then fills a seconds budget with
// the shortest ones first and streams the picks back as minutes/seconds.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+---------------------------------------
//  req_chan  | in  | valid/ready      | minutes, seconds, last_item
//  rsp_chan  | out | valid/ready      | out_minutes, out_seconds, is_valid,
//            |     |                  | last_result
//  csr_*     | in  | csr_we strobe    | csr_wdata = budget in seconds
//
//  Insert: an item that lands behind k longer stored durations reads and
//  compares each of them and shifts it up one slot, then is written into
//  the slot found; a slot above 0 takes one more read and compare first.
//  A dropped item (store full) is not stored and takes no insert steps.
//  Selection reads and compares each inspected entry, with one more read
//  when every entry fits, then a closing step, and per result a reciprocal
//  divide by 60 and then an emit step, plus rsp back-pressure.
//  Reset: synchronous, active high; empties the store and zeroes the budget.
//  req_chan.ready is high only while the sequencer is idle; the last result
//  may still wait in the output register while the next item transfers.
// ----------------------------------------------------------------------------
module greedy_shortest_first_budget_fill_core
   import gsfbf_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   gsfbf_req_if.sink         req_chan,
   gsfbf_rsp_if.source       rsp_chan,
   input  wire               csr_we,
   input  wire [DUR_W-1:0]   csr_wdata
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;   // store address
   localparam int CW = $clog2(MAX_ITEMS + 1);                     // count 0..MAX

   // one-hot sequencer
   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,   // take an item
      ST_INS_RD  = 8'b0000_0010,   // read neighbor below insert slot
      ST_INS_CMP = 8'b0000_0100,   // shift it up or drop new item in
      ST_SEL_RD  = 8'b0000_1000,   // read next shortest
      ST_SEL_CMP = 8'b0001_0000,   // fits the budget?
      ST_FIN     = 8'b0010_0000,   // flush pending pick as final
      ST_DIV     = 8'b0100_0000,   // quotient estimate
      ST_EMIT    = 8'b1000_0000    // fix up and load output register
   } state_type;

   // ---------------------------------------------------------------- regs
   state_type         state_ff,  state_in;
   logic [CW-1:0]     count_ff,  count_in;
   logic [CW-1:0]     pos_ff,    pos_in;     // insert slot
   logic [CW-1:0]     idx_ff,    idx_in;     // selection walk index
   dur_type           budget_ff, budget_in;
   dur_type           rem_ff,    rem_in;     // remaining budget
   dur_type           dur_ff,    dur_in;     // item being inserted
   logic              last_ff,   last_in;
   logic              pend_ff,   pend_in;    // a pick is waiting
   dur_type           pend_v_ff, pend_v_in;
   logic              final_ff,  final_in;   // current emit closes the run
   dur_type           out_v_ff,  out_v_in;
   logic              out_ok_ff, out_ok_in;
   logic              out_lst_ff, out_lst_in;
   logic [QUOT_W-1:0] quot_ff,   quot_in;

   logic              rsp_valid_ff, rsp_valid_in;
   field_type         rsp_min_ff,   rsp_min_in;
   field_type         rsp_sec_ff,   rsp_sec_in;
   logic              rsp_ok_ff,    rsp_ok_in;
   logic              rsp_lst_ff,   rsp_lst_in;

   // ---------------------------------------------------------------- store
   dur_type           store_mem [MAX_ITEMS];
   dur_type           rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   dur_type           wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- datapath
   dur_type           req_dur;
   logic              store_full;
   logic [PROD_W-1:0] recip_prod;
   logic [DUR_W:0]    rem_diff;     // v - q*60, below 120
   logic [QUOT_W-1:0] rem_raw;
   logic              rem_wrap;
   logic [QUOT_W-1:0] quot_fix;
   logic [QUOT_W-1:0] secs_fix;
   logic              rsp_free;

   // minutes*60 + seconds, at most 3843
   assign req_dur    = DUR_W'(DUR_W'(req_chan.minutes) * DUR_W'(SECS_PER_MIN))
                     + DUR_W'(req_chan.seconds);
   assign store_full = (count_ff == CW'(MAX_ITEMS));

   assign recip_prod = PROD_W'(out_v_ff) * PROD_W'(RECIP_60);
   assign rem_diff   = (DUR_W+1)'(out_v_ff)
                     - (DUR_W+1)'((DUR_W+1)'(quot_ff) * (DUR_W+1)'(SECS_PER_MIN));
   assign rem_raw    = rem_diff[QUOT_W-1:0];
   assign rem_wrap   = (rem_raw >= QUOT_W'(SECS_PER_MIN));
   assign quot_fix   = rem_wrap ? quot_ff + QUOT_W'(1) : quot_ff;
   assign secs_fix   = rem_wrap ? rem_raw - QUOT_W'(SECS_PER_MIN) : rem_raw;

   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      budget_in    = csr_we ? csr_wdata : budget_ff;
      rem_in       = rem_ff;
      dur_in       = dur_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      final_in     = final_ff;
      out_v_in     = out_v_ff;
      out_ok_in    = out_ok_ff;
      out_lst_in   = out_lst_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_min_in   = rsp_min_ff;
      rsp_sec_in   = rsp_sec_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_lst_in   = rsp_lst_ff;

      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff[AW-1:0];
      wr_data = dur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               dur_in  = req_dur;
               last_in = req_chan.last_item;
               pos_in  = count_ff;
               if (!store_full) begin
                  state_in = ST_INS_RD;
               end else if (req_chan.last_item) begin
                  // store full: item dropped, selection still runs
                  rem_in   = budget_ff;
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_SEL_RD;
               end
            end
         end

         ST_INS_RD, ST_INS_CMP: begin
            if (state_ff == ST_INS_CMP && rd_data_ff > dur_ff) begin
               // longer neighbor moves up one slot
               wr_en    = 1'b1;
               wr_data  = rd_data_ff;
               pos_in   = pos_ff - CW'(1);
               state_in = ST_INS_RD;
            end else if (state_ff == ST_INS_RD && pos_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(pos_ff - CW'(1));
               state_in = ST_INS_CMP;
            end else begin
               // slot found
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               if (last_ff) begin
                  rem_in   = budget_ff;
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_SEL_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SEL_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_FIN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_SEL_CMP;
            end
         end

         ST_SEL_CMP: begin
            if (rd_data_ff <= rem_ff) begin
               rem_in    = rem_ff - rd_data_ff;
               idx_in    = idx_ff + CW'(1);
               pend_in   = 1'b1;
               pend_v_in = rd_data_ff;
               if (pend_ff) begin
                  // a later pick exists, so the held one is not final
                  out_v_in   = pend_v_ff;
                  out_ok_in  = 1'b1;
                  out_lst_in = 1'b0;
                  final_in   = 1'b0;
                  state_in   = ST_DIV;
               end else begin
                  state_in = ST_SEL_RD;
               end
            end else begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            // flush the held pick as final; if nothing fit, a single flagged-invalid result of zero
            out_v_in   = pend_ff ? pend_v_ff : '0;
            out_ok_in  = pend_ff;
            out_lst_in = 1'b1;
            final_in   = 1'b1;
            pend_in    = 1'b0;
            count_in   = '0;
            state_in   = ST_DIV;
         end

         ST_DIV: begin
            quot_in  = recip_prod[RECIP_SHIFT +: QUOT_W];
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = quot_fix[FIELD_W-1:0];
               rsp_sec_in   = secs_fix[FIELD_W-1:0];
               rsp_ok_in    = out_ok_ff;
               rsp_lst_in   = out_lst_ff;
               state_in     = final_ff ? ST_IDLE : ST_SEL_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         budget_ff    <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         budget_ff    <= budget_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      dur_ff     <= dur_in;
      last_ff    <= last_in;
      pend_v_ff  <= pend_v_in;
      out_v_ff   <= out_v_in;
      out_ok_ff  <= out_ok_in;
      out_lst_ff <= out_lst_in;
      quot_ff    <= quot_in;
      rsp_min_ff <= rsp_min_in;
      rsp_sec_ff <= rsp_sec_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_lst_ff <= rsp_lst_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_minutes = rsp_min_ff;
   assign rsp_chan.out_seconds = rsp_sec_ff;
   assign rsp_chan.is_valid    = rsp_ok_ff;
   assign rsp_chan.last_result = rsp_lst_ff;

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("item count beyond store depth");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> rsp_lst_ff)
      else $error("nothing-fit result not marked final");

   a_secs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sec_ff < FIELD_W'(SECS_PER_MIN)))
      else $error("seconds field out of range");

   a_budget_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEL_CMP) |=> (rem_ff <= $past(rem_ff)))
      else $error("remaining budget grew during selection");

endmodule : greedy_shortest_first_budget_fill_core
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shortest-first budget fill core. Durations go
// in as sets over the request channel. A local model keeps its own sorted
// store and budget and predicts the picks that each closed set returns. Every
// response transfer is checked against the oldest predicted pick.
// ----------------------------------------------------------------------------
module testbench;
   import gsfbf_pkg::*;

   localparam int STORE_DEPTH   = MAX_ITEMS_DEFAULT;
   localparam int CYCLE_LIMIT   = 1000000;
   // Quiet cycles after the last pick before a budget write or the verdict.
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_PRINTS    = 40;

   typedef struct packed {
      field_type minutes;
      field_type seconds;
      logic      is_valid;
      logic      last_result;
   } pick_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   dur_type     csr_wdata;

   gsfbf_req_if req_chan ();
   gsfbf_rsp_if rsp_chan ();

   greedy_shortest_first_budget_fill_core #(
      .MAX_ITEMS (STORE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Model state: the durations of the open set, ascending, plus the budget
   // register as last written. Picks still owed by the core wait in
   // picks_due, oldest first.
   // ---------------------------------------------------------------------
   dur_type     sorted_durations[$];
   dur_type     budget_reg;
   pick_type    picks_due[$];

   int          error_count;
   int unsigned cycle_count;
   int unsigned items_sent;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Global watchdog; a hung core ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("ERROR at %0t: %s", $time, what);
   endtask

   // Insert one accepted duration. A full store drops it. A closing item
   // walks the store shortest first, takes what fits and queues the picks.
   function automatic void load_duration(input field_type mins, input field_type secs,
                                         input logic closes_set);
      dur_type d;
      dur_type left;
      int      pos;
      d = dur_type'(mins * SECS_PER_MIN + secs);
      if (sorted_durations.size() < STORE_DEPTH) begin
         pos = sorted_durations.size();
         while (pos > 0 && sorted_durations[pos-1] > d)
            pos--;
         sorted_durations.insert(pos, d);
      end
      if (!closes_set)
         return;
      left = budget_reg;
      foreach (sorted_durations[i]) begin
         if (sorted_durations[i] > left)
            break;
         left = left - sorted_durations[i];
         picks_due.push_back('{field_type'(sorted_durations[i] / SECS_PER_MIN),
                               field_type'(sorted_durations[i] % SECS_PER_MIN),
                               1'b1, 1'b0});
      end
      // Number of picks from this set = queue growth; zero means a miss.
      if (picks_due.size() == 0 || picks_due[picks_due.size()-1].last_result) begin
         picks_due.push_back('{'0, '0, 1'b0, 1'b1});
      end else begin
         picks_due[picks_due.size()-1].last_result = 1'b1;
      end
      sorted_durations.delete();
   endfunction

   // Response side: random back-pressure, one check per transfer.
   always @(posedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      pick_type got;
      pick_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = '{rsp_chan.out_minutes, rsp_chan.out_seconds,
                 rsp_chan.is_valid, rsp_chan.last_result};
         if (picks_due.size() == 0) begin
            report_mismatch($sformatf("unexpected pick %0d:%0d valid=%b last=%b",
                                      got.minutes, got.seconds, got.is_valid,
                                      got.last_result));
         end else begin
            want = picks_due.pop_front();
            if (got.minutes !== want.minutes || got.seconds !== want.seconds ||
                got.is_valid !== want.is_valid || got.last_result !== want.last_result)
               report_mismatch($sformatf(
                  "pick got %0d:%0d v=%b l=%b, want %0d:%0d v=%b l=%b",
                  got.minutes, got.seconds, got.is_valid, got.last_result,
                  want.minutes, want.seconds, want.is_valid, want.last_result));
         end
      end
   end

   // One request transfer. Valid stays high when called back to back, unless a
   // random sender idle drops it, so the next item is offered without a bubble.
   task automatic send_duration(input field_type mins, input field_type secs,
                                input logic closes_set);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.minutes   <= mins;
      req_chan.seconds   <= secs;
      req_chan.last_item <= closes_set;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      load_duration(mins, secs, closes_set);
      items_sent++;
   endtask

   // Stop sending and let every owed pick drain, then wait out the settle period.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (picks_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_budget(input dur_type value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      budget_reg = value;
      csr_we    <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Directed checks
   // ---------------------------------------------------------------------

   // Budget is zero out of reset: a zero duration still fits, one second
   // does not.
   task automatic test_reset_budget();
      send_duration(6'd0, 6'd0, 1'b1);
      send_duration(6'd0, 6'd1, 1'b1);
   endtask

   // Field extremes; the budget is used up exactly and 63:63 is left out.
   task automatic test_field_extremes();
      write_budget(dur_type'(3599));
      send_duration(6'd63, 6'd63, 1'b0);
      send_duration(6'd59, 6'd59, 1'b0);
      send_duration(6'd0,  6'd0,  1'b1);
   endtask

   // 1:00 and 0:60 are the same duration; the last copy no longer fits.
   task automatic test_equal_durations();
      write_budget(dur_type'(150));
      send_duration(6'd1, 6'd0,  1'b0);
      send_duration(6'd0, 6'd60, 1'b0);
      send_duration(6'd1, 6'd0,  1'b0);
      send_duration(6'd0, 6'd30, 1'b1);
   endtask

   // A full 12-bit budget lets 3843 s through; its minutes wrap to zero.
   task automatic test_minutes_wrap();
      write_budget(dur_type'(4095));
      send_duration(6'd63, 6'd63, 1'b0);
      send_duration(6'd0,  6'd1,  1'b1);
   endtask

   // Shortest entry already exceeds the budget; then sets closed back to
   // back so the next item lands while the last pick may still be parked.
   task automatic test_nothing_fits();
      write_budget(dur_type'(100));
      send_duration(6'd2, 6'd0,  1'b0);
      send_duration(6'd1, 6'd41, 1'b1);
      send_duration(6'd0, 6'd5,  1'b0);
      send_duration(6'd0, 6'd7,  1'b1);
      send_duration(6'd0, 6'd2,  1'b1);
      send_duration(6'd0, 6'd40, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Random sets. Most are short; some run up to the store depth and a few
   // overflow it, so that late durations get dropped. Durations lean short so
   // that sets return many picks.
   // ---------------------------------------------------------------------
   task automatic send_random_set();
      int unsigned set_size;
      int unsigned roll;
      field_type   mins;
      field_type   secs;
      roll = $urandom_range(99);
      if (roll < 70)
         set_size = $urandom_range(8, 1);
      else if (roll < 92)
         set_size = $urandom_range(STORE_DEPTH, 9);
      else
         set_size = $urandom_range(STORE_DEPTH + 8, STORE_DEPTH + 1);
      for (int unsigned i = 0; i < set_size; i++) begin
         roll = $urandom_range(99);
         if (roll < 50)
            mins = field_type'($urandom_range(1));
         else if (roll < 80)
            mins = field_type'($urandom_range(9));
         else
            mins = field_type'($urandom_range(63));
         secs = field_type'($urandom_range(63));
         send_duration(mins, secs, i == set_size - 1);
      end
   endtask

   task automatic test_random_traffic(input int unsigned sender_pct,
                                      input int unsigned receiver_pct,
                                      input int unsigned item_goal);
      int unsigned goal;
      int unsigned roll;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      goal = items_sent + item_goal;
      while (items_sent < goal) begin
         roll = $urandom_range(99);
         if (roll < 5)
            write_budget('0);
         else if (roll < 10)
            write_budget(dur_type'(3599));
         else if (roll < 20)
            write_budget(dur_type'($urandom_range(600)));
         else if (roll < 30)
            write_budget(dur_type'($urandom_range(3599)));
         else if (roll < 40)
            wait_idle();
         send_random_set();
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.minutes   = '0;
      req_chan.seconds   = '0;
      req_chan.last_item = 1'b0;
      rsp_chan.ready     = 1'b0;
      budget_reg         = '0;
      error_count        = 0;
      cycle_count        = 0;
      items_sent         = 0;
      send_idle_pct      = 10;
      recv_idle_pct      = 85;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_budget();
      test_field_extremes();
      test_equal_durations();
      test_minutes_wrap();
      test_nothing_fits();

      test_random_traffic(10, 85, 170);
      test_random_traffic(85, 10, 170);
      test_random_traffic(0, 0, 170);

      wait_idle();
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
